>>> src/lcs_oc_pkg.sv
`default_nettype none
package lcs_oc_pkg;

  localparam int MAX_LEN   = 32;
  localparam int JOB_BITS  = 8;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int TAB_DEPTH = MAX_LEN * MAX_LEN;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int CLEN_W    = 6;
  localparam int CLEN_MAX  = 63;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  typedef struct packed {
    logic [JOB_BITS-1:0] job_a;
    logic [JOB_BITS-1:0] job_b;
    logic                keep;
    logic                last;
    logic [IDX_W-1:0]    index;
    logic [LEN_W-1:0]    n;
    logic                ovf;
  } entry_t;

endpackage
`default_nettype wire

>>> src/lcs_oc_front.sv
`default_nettype none
module lcs_oc_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic [lcs_oc_pkg::JOB_BITS-1:0]  job_a,
  input  wire logic [lcs_oc_pkg::JOB_BITS-1:0]  job_b,
  input  wire logic                             last_pair,
  input  wire logic                             full,
  output      logic                             push,
  output      lcs_oc_pkg::entry_t               entry
);

  logic [lcs_oc_pkg::LEN_W-1:0] count;
  logic                         ovf;
  logic                         keep;

  assign busy = full;
  assign push = start && !busy;
  assign keep = count < lcs_oc_pkg::LEN_W'(lcs_oc_pkg::MAX_LEN);

  always_comb begin
    entry.job_a = job_a;
    entry.job_b = job_b;
    entry.keep  = keep;
    entry.last  = last_pair;
    entry.index = count[lcs_oc_pkg::IDX_W-1:0];
    entry.n     = keep ? count + lcs_oc_pkg::LEN_W'(1) : count;
    entry.ovf   = ovf || !keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (push) begin
      if (last_pair) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= entry.n;
        ovf   <= entry.ovf;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/lcs_oc_queue.sv
`default_nettype none
module lcs_oc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire lcs_oc_pkg::entry_t wr_entry,
  output      logic               full,
  input  wire logic               pop,
  output      logic               empty,
  output      lcs_oc_pkg::entry_t head
);

  lcs_oc_pkg::entry_t             slots [lcs_oc_pkg::Q_DEPTH];
  logic [lcs_oc_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [lcs_oc_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [lcs_oc_pkg::Q_CNT_W-1:0] fill;

  assign full  = fill == lcs_oc_pkg::Q_CNT_W'(lcs_oc_pkg::Q_DEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + lcs_oc_pkg::Q_PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + lcs_oc_pkg::Q_PTR_W'(1);
      end
      fill <= fill + lcs_oc_pkg::Q_CNT_W'(push && !full) - lcs_oc_pkg::Q_CNT_W'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

>>> src/lcs_oc_back.sv
`default_nettype none
module lcs_oc_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lcs_oc_pkg::entry_t               head,
  input  wire logic                             empty,
  output      logic                             pop,
  output      logic                             result_valid,
  output      logic [lcs_oc_pkg::JOB_BITS-1:0]  child_one_job,
  output      logic [lcs_oc_pkg::JOB_BITS-1:0]  child_two_job,
  output      logic [lcs_oc_pkg::CLEN_W-1:0]    common_length,
  output      logic                             overflow,
  output      logic                             last_out
);

  localparam int JB = lcs_oc_pkg::JOB_BITS;
  localparam int LW = lcs_oc_pkg::LEN_W;
  localparam int IW = lcs_oc_pkg::IDX_W;
  localparam int AW = lcs_oc_pkg::TAB_AW;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_FILL_A = 11'b00000000010,
    S_FILL_B = 11'b00000000100,
    S_BT_A   = 11'b00000001000,
    S_BT_B   = 11'b00000010000,
    S_BT_C   = 11'b00000100000,
    S_BT_D   = 11'b00001000000,
    S_P1_A   = 11'b00010000000,
    S_P1_B   = 11'b00100000000,
    S_P2_A   = 11'b01000000000,
    S_P2_B   = 11'b10000000000
  } state_t;

  state_t state;

  logic [JB-1:0] seq_first  [lcs_oc_pkg::MAX_LEN];
  logic [JB-1:0] seq_second [lcs_oc_pkg::MAX_LEN];
  logic [JB-1:0] common_one [lcs_oc_pkg::MAX_LEN];
  logic [JB-1:0] common_two [lcs_oc_pkg::MAX_LEN];
  logic [JB-1:0] filler_one [lcs_oc_pkg::MAX_LEN];
  logic [JB-1:0] filler_two [lcs_oc_pkg::MAX_LEN];
  logic [LW-1:0] len_table  [lcs_oc_pkg::TAB_DEPTH];

  logic [JB-1:0] sf_rd, ss_rd, cs1_rd, cs2_rd, fl1_rd, fl2_rd;
  logic [LW-1:0] tab_rd;
  logic [IW-1:0] sf_ra, ss_ra;
  logic [LW-1:0] tab_r, tab_c, tab_rm1, tab_cm1;
  logic [AW-1:0] tab_ra, tab_wa;
  logic [LW-1:0] wr_rm1, wr_cm1;

  logic [LW-1:0] n_q, len_q, pos, r, c, k1, k2, nf1, nf2, f1, f2;
  logic [LW-1:0] left_v, diag_v, cur_q, up_q;
  logic [IW-1:0] p;
  logic [JB-1:0] sf_hold;
  logic          ovf_q;

  logic [LW-1:0] up_f, cell_v, lf_b;
  logic          p_last;
  logic          m1, m2;
  logic [JB-1:0] ch1, ch2;
  logic [LW:0]   len_ext;

  assign pop    = (state == S_IDLE) && !empty;
  assign p_last = (LW'(p) + LW'(1)) == n_q;

  always_comb begin
    sf_ra = p;
    ss_ra = p;
    tab_r = r;
    tab_c = c;
    unique case (state)
      S_FILL_A, S_FILL_B: begin
        sf_ra = IW'(r - LW'(1));
        ss_ra = IW'(c - LW'(1));
        tab_r = r - LW'(1);
      end
      S_BT_A, S_BT_B, S_BT_C, S_BT_D: begin
        sf_ra = IW'(r - LW'(1));
        if (state == S_BT_B) begin
          tab_r = r - LW'(1);
        end else if (state == S_BT_C) begin
          tab_c = c - LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign tab_rm1 = tab_r - LW'(1);
  assign tab_cm1 = tab_c - LW'(1);
  assign tab_ra  = AW'(int'(tab_rm1[IW-1:0]) * lcs_oc_pkg::MAX_LEN + int'(tab_cm1[IW-1:0]));
  assign wr_rm1  = r - LW'(1);
  assign wr_cm1  = c - LW'(1);
  assign tab_wa  = AW'(int'(wr_rm1[IW-1:0]) * lcs_oc_pkg::MAX_LEN + int'(wr_cm1[IW-1:0]));

  // table cell update
  assign up_f   = (r == LW'(1)) ? '0 : tab_rd;
  assign cell_v = (sf_rd == ss_rd) ? diag_v + LW'(1) : ((up_f > left_v) ? up_f : left_v);
  assign lf_b   = (c == LW'(1)) ? '0 : tab_rd;

  // child selection during emit
  assign m1  = (k1 < len_q) && (sf_rd == cs1_rd);
  assign m2  = (k2 < len_q) && (ss_rd == cs2_rd);
  assign ch1 = m1 ? sf_rd : ((f1 < nf1) ? fl1_rd : '0);
  assign ch2 = m2 ? ss_rd : ((f2 < nf2) ? fl2_rd : '0);
  assign len_ext = {1'b0, len_q};

  always_ff @(posedge clk) begin
    if (pop && head.keep) begin
      seq_first[head.index]  <= head.job_a;
      seq_second[head.index] <= head.job_b;
    end
    sf_rd <= seq_first[sf_ra];
    ss_rd <= seq_second[ss_ra];
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL_B) begin
      len_table[tab_wa] <= cell_v;
    end
    tab_rd <= len_table[tab_ra];
  end

  always_ff @(posedge clk) begin
    if ((state == S_BT_D) && (cur_q != '0) && (cur_q > up_q) && (cur_q > lf_b) &&
        (pos != '0)) begin
      common_one[IW'(pos - LW'(1))] <= sf_hold;
      common_two[IW'(pos - LW'(1))] <= sf_hold;
    end
    cs1_rd <= common_one[k1[IW-1:0]];
    cs2_rd <= common_two[k2[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_P1_B) begin
      if (!((k1 < len_q) && (ss_rd == cs1_rd))) begin
        filler_one[nf1[IW-1:0]] <= ss_rd;
      end
      if (!((k2 < len_q) && (sf_rd == cs2_rd))) begin
        filler_two[nf2[IW-1:0]] <= sf_rd;
      end
    end
    fl1_rd <= filler_one[f1[IW-1:0]];
    fl2_rd <= filler_two[f2[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop && head.last) begin
            n_q    <= head.n;
            ovf_q  <= head.ovf;
            r      <= LW'(1);
            c      <= LW'(1);
            left_v <= '0;
            diag_v <= '0;
            state  <= S_FILL_A;
          end
        end
        S_FILL_A: state <= S_FILL_B;
        S_FILL_B: begin
          if (c == n_q) begin
            left_v <= '0;
            diag_v <= '0;
            if (r == n_q) begin
              len_q <= cell_v;
              pos   <= cell_v;
              r     <= n_q;
              c     <= n_q;
              state <= S_BT_A;
            end else begin
              c     <= LW'(1);
              r     <= r + LW'(1);
              state <= S_FILL_A;
            end
          end else begin
            left_v <= cell_v;
            diag_v <= up_f;
            c      <= c + LW'(1);
            state  <= S_FILL_A;
          end
        end
        S_BT_A: begin
          if ((r == '0) || (c == '0)) begin
            p     <= '0;
            k1    <= '0;
            k2    <= '0;
            nf1   <= '0;
            nf2   <= '0;
            state <= S_P1_A;
          end else begin
            state <= S_BT_B;
          end
        end
        S_BT_B: begin
          cur_q   <= tab_rd;
          sf_hold <= sf_rd;
          state   <= S_BT_C;
        end
        S_BT_C: begin
          up_q  <= (r == LW'(1)) ? '0 : tab_rd;
          state <= S_BT_D;
        end
        S_BT_D: begin
          if (cur_q == '0) begin
            p     <= '0;
            k1    <= '0;
            k2    <= '0;
            nf1   <= '0;
            nf2   <= '0;
            state <= S_P1_A;
          end else begin
            if ((cur_q > up_q) && (cur_q > lf_b)) begin
              if (pos != '0) begin
                pos <= pos - LW'(1);
              end
              r <= r - LW'(1);
              c <= c - LW'(1);
            end else if (up_q > lf_b) begin
              r <= r - LW'(1);
            end else begin
              c <= c - LW'(1);
            end
            state <= S_BT_A;
          end
        end
        S_P1_A: state <= S_P1_B;
        S_P1_B: begin
          if (!((k1 < len_q) && (ss_rd == cs1_rd))) begin
            nf1 <= nf1 + LW'(1);
          end
          if (!((k2 < len_q) && (sf_rd == cs2_rd))) begin
            nf2 <= nf2 + LW'(1);
          end
          if (p_last) begin
            p     <= '0;
            k1    <= '0;
            k2    <= '0;
            f1    <= '0;
            f2    <= '0;
            state <= S_P2_A;
          end else begin
            if ((k1 < len_q) && (ss_rd == cs1_rd)) begin
              k1 <= k1 + LW'(1);
            end
            if ((k2 < len_q) && (sf_rd == cs2_rd)) begin
              k2 <= k2 + LW'(1);
            end
            p     <= p + IW'(1);
            state <= S_P1_A;
          end
        end
        S_P2_A: state <= S_P2_B;
        S_P2_B: begin
          result_valid  <= 1'b1;
          child_one_job <= ch1;
          child_two_job <= ch2;
          common_length <= (len_ext > (LW + 1)'(lcs_oc_pkg::CLEN_MAX)) ?
                           lcs_oc_pkg::CLEN_W'(lcs_oc_pkg::CLEN_MAX) :
                           lcs_oc_pkg::CLEN_W'(len_q);
          overflow      <= ovf_q;
          last_out      <= p_last;
          if (m1) begin
            k1 <= k1 + LW'(1);
          end else if (f1 < nf1) begin
            f1 <= f1 + LW'(1);
          end
          if (m2) begin
            k2 <= k2 + LW'(1);
          end else if (f2 < nf2) begin
            f2 <= f2 + LW'(1);
          end
          if (p_last) begin
            state <= S_IDLE;
          end else begin
            p     <= p + IW'(1);
            state <= S_P2_A;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // every diagonal step of the backtrack lands one common entry
  a_pos_spent: assert property (@(posedge clk) disable iff (rst)
    (state == S_P1_A && p == '0 && k1 == '0 && nf1 == '0) |-> pos == '0)
    else $error("backtrack left common entries unwritten");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_out) |=> !result_valid)
    else $error("result beat after final position");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (len_q <= n_q))
    else $error("common length above batch size");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pop)
    else $error("queue drained while batch in progress");

endmodule
`default_nettype wire

>>> src/lcs_order_crossover_top.sv
// lcs order crossover
// input: a beat is taken on a rising edge with start high and busy low; it carries
// one pair job_a/job_b, and last_pair closes the batch (up to 32 pairs kept,
// further pairs dropped and reported through overflow)
// output: one beat per loaded position, marked by result_valid for one cycle,
// carrying child_one_job, child_two_job, common_length, overflow and last_out
// on the final position; the receiver cannot hold beats off
// a two-entry queue sits between the input stage and the compute engine, so
// pairs of the next batch are taken while the engine works; busy rises only
// when the queue is full
// per batch of n pairs the engine fills the table cell by cell (one table memory
// port, read then write per cell), walks the backtrack (at most 2*n steps, each
// through states S_BT_A to S_BT_D), then builds the fillers and emits the beats;
// for large batches the table fill takes most of the engine's time
// reset clears the queue, counters and engine state; stored jobs are kept
`default_nettype none
module lcs_order_crossover_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic [lcs_oc_pkg::JOB_BITS-1:0]  job_a,
  input  wire logic [lcs_oc_pkg::JOB_BITS-1:0]  job_b,
  input  wire logic                             last_pair,
  output      logic                             result_valid,
  output      logic [lcs_oc_pkg::JOB_BITS-1:0]  child_one_job,
  output      logic [lcs_oc_pkg::JOB_BITS-1:0]  child_two_job,
  output      logic [lcs_oc_pkg::CLEN_W-1:0]    common_length,
  output      logic                             overflow,
  output      logic                             last_out
);

  lcs_oc_pkg::entry_t wr_entry;
  lcs_oc_pkg::entry_t head;
  logic               push, full, pop, empty;

  lcs_oc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .job_a     (job_a),
    .job_b     (job_b),
    .last_pair (last_pair),
    .full      (full),
    .push      (push),
    .entry     (wr_entry)
  );

  lcs_oc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  lcs_oc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .result_valid  (result_valid),
    .child_one_job (child_one_job),
    .child_two_job (child_two_job),
    .common_length (common_length),
    .overflow      (overflow),
    .last_out      (last_out)
  );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN  = lcs_oc_pkg::MAX_LEN;
  localparam int JOB_BITS = lcs_oc_pkg::JOB_BITS;
  localparam int CLEN_W   = lcs_oc_pkg::CLEN_W;
  localparam int CLEN_MAX = lcs_oc_pkg::CLEN_MAX;

  typedef struct {
    logic [JOB_BITS-1:0] c1;
    logic [JOB_BITS-1:0] c2;
    logic [CLEN_W-1:0]   clen;
    logic                ovf;
    logic                lst;
  } child_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [JOB_BITS-1:0] job_a = '0;
  logic [JOB_BITS-1:0] job_b = '0;
  logic last_pair = 1'b0;
  logic busy, result_valid, overflow, last_out;
  logic [JOB_BITS-1:0] child_one_job, child_two_job;
  logic [CLEN_W-1:0] common_length;

  child_beat_t expected_children[$];
  logic [JOB_BITS-1:0] par_a[$];
  logic [JOB_BITS-1:0] par_b[$];
  bit par_ovf;
  int error_count = 0;
  int send_gap_pct = 0;

  lcs_order_crossover_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .job_a(job_a), .job_b(job_b), .last_pair(last_pair),
    .result_valid(result_valid), .child_one_job(child_one_job),
    .child_two_job(child_two_job), .common_length(common_length),
    .overflow(overflow), .last_out(last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // child built in own order around the common subsequence
  task automatic cross_child(input logic [JOB_BITS-1:0] own[], input logic [JOB_BITS-1:0] oth[],
                             input logic [JOB_BITS-1:0] cs[], input int n, input int len,
                             output logic [JOB_BITS-1:0] child[]);
    logic [JOB_BITS-1:0] fill[$];
    int k;
    fill = {};
    child = new[n];
    k = 0;
    for (int p = 0; p < n; p++)
      if (k < len && oth[p] == cs[k]) k++;
      else fill.push_back(oth[p]);
    k = 0;
    for (int p = 0; p < n; p++) begin
      if (k < len && own[p] == cs[k]) begin
        child[p] = own[p];
        k++;
      end else if (fill.size() > 0) child[p] = fill.pop_front();
      else child[p] = '0;
    end
  endtask

  task automatic predict_crossover();
    int n, len, r, c, pos;
    int tab[MAX_LEN+1][MAX_LEN+1];
    logic [JOB_BITS-1:0] a[], b[], cs[], ch1[], ch2[];
    child_beat_t bt;
    n = par_a.size();
    a = new[n];
    b = new[n];
    cs = new[MAX_LEN];
    for (int i = 0; i < n; i++) begin
      a[i] = par_a[i];
      b[i] = par_b[i];
    end
    for (int i = 0; i <= MAX_LEN; i++)
      for (int j = 0; j <= MAX_LEN; j++) tab[i][j] = 0;
    for (r = 1; r <= n; r++)
      for (c = 1; c <= n; c++)
        if (a[r-1] == b[c-1]) tab[r][c] = tab[r-1][c-1] + 1;
        else tab[r][c] = tab[r-1][c] > tab[r][c-1] ? tab[r-1][c] : tab[r][c-1];
    len = tab[n][n];
    pos = len;
    r = n;
    c = n;
    while (r > 0 && c > 0 && tab[r][c] != 0) begin
      if (tab[r][c] > tab[r-1][c] && tab[r][c] > tab[r][c-1]) begin
        if (pos > 0) begin
          pos--;
          cs[pos] = a[r-1];
        end
        r--;
        c--;
      end else if (tab[r-1][c] > tab[r][c-1]) r--;
      else c--;
    end
    cross_child(a, b, cs, n, len, ch1);
    cross_child(b, a, cs, n, len, ch2);
    for (int p = 0; p < n; p++) begin
      bt.c1 = ch1[p];
      bt.c2 = ch2[p];
      bt.clen = CLEN_W'(len > CLEN_MAX ? CLEN_MAX : len);
      bt.ovf = par_ovf;
      bt.lst = (p == n - 1);
      expected_children.push_back(bt);
    end
    par_a = {};
    par_b = {};
    par_ovf = 0;
  endtask

  task automatic send_pair(input logic [JOB_BITS-1:0] ja, input logic [JOB_BITS-1:0] jb,
                           input bit lst);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    job_a <= ja;
    job_b <= jb;
    last_pair <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (par_a.size() < MAX_LEN) begin
      par_a.push_back(ja);
      par_b.push_back(jb);
    end else par_ovf = 1;
    if (lst) predict_crossover();
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_children.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        child_beat_t w;
        w = expected_children.pop_front();
        if (child_one_job !== w.c1)
          report_mismatch("child_one_job", int'(child_one_job), int'(w.c1));
        if (child_two_job !== w.c2)
          report_mismatch("child_two_job", int'(child_two_job), int'(w.c2));
        if (common_length !== w.clen)
          report_mismatch("common_length", int'(common_length), int'(w.clen));
        if (overflow !== w.ovf) report_mismatch("overflow", int'(overflow), int'(w.ovf));
        if (last_out !== w.lst) report_mismatch("last_out", int'(last_out), int'(w.lst));
      end
    end
  end

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_children.size() > 0) @(posedge clk);
  endtask

  // kinds 1 and 2 give a permutation-like batch for realistic crossovers; kind 0 gives random pairs
  task automatic send_batch(input int n, input int kind);
    logic [JOB_BITS-1:0] pa[$], pb[$];
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: pa.push_back(JOB_BITS'($urandom_range(255)));
        1: pa.push_back(JOB_BITS'($urandom_range(3)));
        default: pa.push_back(JOB_BITS'(i + int'($urandom_range(200))));
      endcase
      pb.push_back(kind == 0 ? JOB_BITS'($urandom_range(255)) : pa[i]);
    end
    if (kind != 0) pb.shuffle();
    for (int i = 0; i < n; i++) send_pair(pa[i], pb[i], i == n - 1);
  endtask

  task automatic test_directed();
    send_pair(8'h00, 8'hff, 1'b1);
    send_pair(8'hab, 8'hab, 1'b1);
    send_pair(8'hff, 8'h00, 1'b0);
    send_pair(8'h00, 8'hff, 1'b1);
    send_pair(8'h55, 8'haa, 1'b0);
    send_pair(8'haa, 8'h55, 1'b0);
    send_pair(8'h55, 8'haa, 1'b1);
    drain_results();
    send_batch(MAX_LEN, 2);
    drain_results();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < MAX_LEN + 3; i++)
      send_pair(JOB_BITS'($urandom_range(255)), JOB_BITS'($urandom_range(255)),
                i == MAX_LEN + 2);
    for (int i = 0; i < MAX_LEN; i++)
      send_pair(JOB_BITS'(i), JOB_BITS'(MAX_LEN - i), i == MAX_LEN - 1);
    drain_results();
  endtask

  task automatic test_random(input int gap, input int items);
    int sent;
    int n;
    send_gap_pct = gap;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(9) == 0 ? $urandom_range(MAX_LEN, 20) : $urandom_range(12, 1);
      send_batch(n, $urandom_range(2));
      sent += n;
    end
    drain_results();
    send_gap_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(0, 50);
    test_random(48, 50);
    test_random(0, 50);
    test_random(31, 50);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_children.size() == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
